### hdl/tlps_pkg.sv
// ----------------------------------------------------------------------------
// tlps_pkg: shared types and constants of the two-level priority scheduler
// Item layouts, result codes, sizing constants and the in-source ordering.
// ----------------------------------------------------------------------------
package tlps_pkg;

  localparam int NUM_SOURCES = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W  = (CNT_W > SRC_W + 1) ? CNT_W : SRC_W + 1;
  localparam int ADDR_W = SRC_W + SLOT_W;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Operation codes of the mode field.
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_POP = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  source_id;
    logic [9:0]  item_tag;
    logic [7:0]  priority_req;
    logic [15:0] cost;
    logic [15:0] ready_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  out_tag;
    logic [3:0]  out_source;
    logic [15:0] out_cost;
    logic [7:0]  out_priority;
    logic [15:0] out_ready_time;
    logic        still_pending;
  } res_item_t;

  // One stored queue entry.
  typedef struct packed {
    logic [9:0]  tag;
    logic [7:0]  prio;
    logic [15:0] cost;
    logic [15:0] ready;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic add_exec;
    logic scan_step;
    logic pick;
    logic sh_rd;
    logic sh_wr;
    logic dec;
    logic h_rd;
    logic h_cmp;
    logic h_com;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic found;
    logic idx_lt_lim;
    logic lim_one;
    logic out_free;
  } stat_t;

  // True if entry a ranks strictly ahead of entry b inside one source.
  function automatic logic entry_better(entry_t a, entry_t b);
    logic r;
    if (a.prio != b.prio) begin
      r = a.prio > b.prio;
    end else if (a.cost != b.cost) begin
      r = a.cost < b.cost;
    end else begin
      r = a.ready < b.ready;
    end
    return r;
  endfunction

endpackage

### hdl/tlps_if.sv
// ----------------------------------------------------------------------------
// tlps_if: valid/ready channels of the scheduler
// One interface for input items and one for result items.
// ----------------------------------------------------------------------------
interface tlps_in_if import tlps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tlps_out_if import tlps_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/tlps_ctrl.sv
// ----------------------------------------------------------------------------
// tlps_ctrl: sequencing state machine of the scheduler
// Steps the datapath through add, source scan, shift and head rescan.
// ----------------------------------------------------------------------------
module tlps_ctrl import tlps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_mode,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_ADD  = 11'b00000000010,
    S_SCAN = 11'b00000000100,
    S_PICK = 11'b00000001000,
    S_SHRD = 11'b00000010000,
    S_SHWR = 11'b00000100000,
    S_DEC  = 11'b00001000000,
    S_HRD  = 11'b00010000000,
    S_HCMP = 11'b00100000000,
    S_HCOM = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_mode == MODE_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        cmd.add_exec = 1'b1;
        state_nxt    = S_OUT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = stat.found ? S_SHRD : S_OUT;
      end
      S_SHRD: begin
        if (stat.idx_lt_lim) begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHRD;
      end
      S_DEC: begin
        cmd.dec   = 1'b1;
        state_nxt = stat.lim_one ? S_OUT : S_HRD;
      end
      S_HRD: begin
        if (stat.idx_lt_lim) begin
          cmd.h_rd  = 1'b1;
          state_nxt = S_HCMP;
        end else begin
          state_nxt = S_HCOM;
        end
      end
      S_HCMP: begin
        cmd.h_cmp = 1'b1;
        state_nxt = S_HRD;
      end
      S_HCOM: begin
        cmd.h_com = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hdl/tlps_dp.sv
// ----------------------------------------------------------------------------
// tlps_dp: datapath of the scheduler
// Item memory, per-source counts and cached heads, scan and output register.
// ----------------------------------------------------------------------------
module tlps_dp import tlps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  entry_t               mem [NUM_SOURCES * QUEUE_DEPTH];
  entry_t               rd_r;
  logic [CNT_W-1:0]     cnt_r   [NUM_SOURCES];
  entry_t               hd_r    [NUM_SOURCES];
  logic [SLOT_W-1:0]    hslot_r [NUM_SOURCES];

  in_item_t             req_r;
  logic [SRC_W-1:0]     sel_r;
  logic [IDX_W-1:0]     idx_r;
  logic [CNT_W-1:0]     lim_r;
  logic                 bestf_r;
  logic [15:0]          bestc_r;
  entry_t               besti_r;
  logic [SLOT_W-1:0]    bests_r;
  res_item_t            res_r;
  logic                 out_valid_r;
  res_item_t            out_r;

  logic [SRC_W-1:0]     ptr;
  logic [CNT_W-1:0]     cur_cnt;
  entry_t               cur_hd;
  entry_t               new_e;
  logic                 full_s;
  logic [IDX_W-1:0]     idx_m1;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  entry_t               mem_wd;
  logic                 mem_re;
  logic                 pending;
  res_item_t            add_res;
  res_item_t            pick_res;
  res_item_t            out_nxt;

  // Per-source tables are read at one place: the scan counter or the selection.
  assign ptr     = cmd.scan_step ? idx_r[SRC_W-1:0] : sel_r;
  assign cur_cnt = cnt_r[ptr];
  assign cur_hd  = hd_r[ptr];
  assign new_e   = '{tag: req_r.item_tag, prio: req_r.priority_req,
                     cost: req_r.cost, ready: req_r.ready_time};
  assign full_s  = (cur_cnt == CNT_W'(QUEUE_DEPTH)) ||
                   ({1'b0, req_r.source_id} >= 5'(NUM_SOURCES));
  assign idx_m1  = idx_r - IDX_W'(1);

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {sel_r, cur_cnt[SLOT_W-1:0]};
    mem_wd = new_e;
    if (cmd.add_exec && !full_s) begin
      mem_we = 1'b1;
    end else if (cmd.sh_wr) begin
      mem_we = 1'b1;
      mem_wa = {sel_r, idx_m1[SLOT_W-1:0]};
      mem_wd = rd_r;
    end
  end
  assign mem_re = cmd.sh_rd || cmd.h_rd;

  // Item memory with a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[{sel_r, idx_r[SLOT_W-1:0]}];
  end

  // Per-source counts, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) cnt_r[i] <= '0;
    end else if (cmd.add_exec && !full_s) begin
      cnt_r[ptr] <= cur_cnt + CNT_W'(1);
    end else if (cmd.dec) begin
      cnt_r[ptr] <= lim_r - CNT_W'(1);
    end
  end

  // Cached head of each source; valid only while its count is nonzero.
  always_ff @(posedge clk) begin
    if (cmd.add_exec && !full_s &&
        (cur_cnt == '0 || entry_better(new_e, cur_hd))) begin
      hd_r[ptr]    <= new_e;
      hslot_r[ptr] <= cur_cnt[SLOT_W-1:0];
    end else if (cmd.h_com) begin
      hd_r[ptr]    <= besti_r;
      hslot_r[ptr] <= bests_r;
    end
  end

  // Result of an add and of a pop, built whole before they are registered.
  always_comb begin
    add_res        = '0;
    add_res.status = full_s ? ST_FULL : ST_OK;
    pick_res       = '0;
    if (bestf_r) begin
      pick_res.status         = ST_OK;
      pick_res.out_tag        = cur_hd.tag;
      pick_res.out_source     = 4'(sel_r);
      pick_res.out_cost       = cur_hd.cost;
      pick_res.out_priority   = cur_hd.prio;
      pick_res.out_ready_time = cur_hd.ready;
    end else begin
      pick_res.status = ST_EMPTY;
    end
  end

  // Working registers for scan, shift and rescan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_data;
      sel_r   <= in_data.source_id[SRC_W-1:0];
      idx_r   <= '0;
      bestf_r <= 1'b0;
    end
    if (cmd.add_exec) res_r <= add_res;
    // Lowest head cost wins; ascending order keeps the lower source on a tie.
    if (cmd.scan_step) begin
      if (cur_cnt != '0 && (!bestf_r || cur_hd.cost < bestc_r)) begin
        bestf_r <= 1'b1;
        bestc_r <= cur_hd.cost;
        sel_r   <= idx_r[SRC_W-1:0];
      end
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.pick) begin
      res_r <= pick_res;
      if (bestf_r) begin
        idx_r <= IDX_W'(hslot_r[ptr]) + IDX_W'(1);
        lim_r <= cur_cnt;
      end
    end
    if (cmd.sh_wr) idx_r <= idx_r + IDX_W'(1);
    if (cmd.dec) begin
      lim_r   <= lim_r - CNT_W'(1);
      idx_r   <= '0;
      bestf_r <= 1'b0;
    end
    // Strictly better only, so the earliest of equal entries stays head.
    if (cmd.h_cmp) begin
      if (!bestf_r || entry_better(rd_r, besti_r)) begin
        besti_r <= rd_r;
        bests_r <= idx_r[SLOT_W-1:0];
      end
      bestf_r <= 1'b1;
      idx_r   <= idx_r + IDX_W'(1);
    end
  end

  // Any source still holding items.
  always_comb begin
    pending = 1'b0;
    for (int i = 0; i < NUM_SOURCES; i++) pending = pending | (cnt_r[i] != '0);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt               = res_r;
    out_nxt.still_pending = pending;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat.scan_last  = (idx_r == IDX_W'(NUM_SOURCES - 1));
  assign stat.found      = bestf_r;
  assign stat.idx_lt_lim = (idx_r < IDX_W'(lim_r));
  assign stat.lim_one    = (lim_r == CNT_W'(1));
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

### hdl/two_level_priority_scheduler_core.sv
// A pop scans all 16 sources for the lowest head cost, then shifts the items
// behind the popped one down a slot and rescans that source for its new head,
// both through the registered item memory port; a pop on an empty scheduler
// and a pop of the last item of a source skip the shift and the rescan.
// Throughput: one item at a time; the next item is taken once the last result
// is in the output register. Reset (rst_n low, synchronous) empties all queues.
// ----------------------------------------------------------------------------
// two_level_priority_scheduler_core: two-level priority scheduler top level
// Joins the controller and the datapath to the input and result channels.
// ----------------------------------------------------------------------------
module two_level_priority_scheduler_core import tlps_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  tlps_in_if.sink    in_ch,
  tlps_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  tlps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.data.mode),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  tlps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );

endmodule

### hdl/tlps_checker.sv
// ----------------------------------------------------------------------------
// tlps_checker: port-level assertions of the scheduler
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tlps_checker import tlps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input res_item_t out_data
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only the three defined status codes appear.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3)
    else $error("undefined status code");

  // A result whose status is not OK carries no tag, cost or priority.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.out_tag == '0 &&
      out_data.out_cost == '0 && out_data.out_priority == '0)
    else $error("failed step carries item fields");

  // A pop on an empty scheduler leaves nothing pending.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> !out_data.still_pending)
    else $error("empty pop reports pending items");

endmodule

bind two_level_priority_scheduler_core tlps_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
